[src/rpgr_pkg.sv]
// ----------------------------------------------------------------------------
// rpgr_pkg
// Shared constants, register codes and types of the rotated panel glyph
// renderer.
// ----------------------------------------------------------------------------
package rpgr_pkg;

   localparam int GLYPH_COUNT  = 96;
   localparam int GLYPH_WIDTH  = 5;
   localparam int GLYPH_HEIGHT = 7;
   localparam int MAX_PANELS   = 16;

   localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_WIDTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // field widths
   localparam int KIND_W   = 1;
   localparam int FIDX_W   = 9;
   localparam int FBYTE_W  = 8;
   localparam int CODE_W   = 8;
   localparam int POS_W    = 12;
   localparam int PHYS_X_W = 9;
   localparam int PHYS_Y_W = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;
   localparam int PANREG_W   = 5;
   localparam int FIRST_W    = 6;

   // panel geometry
   localparam int PAN_W   = $clog2(MAX_PANELS + 1);
   localparam int LX_W    = $clog2(MAX_PANELS * 16);
   localparam int LW_W    = LX_W + 1;
   localparam int LY_W    = $clog2(MAX_PANELS * 32);
   localparam int LH_W    = LY_W + 1;
   localparam int REM_W   = LX_W - 4;
   localparam int HI_W    = POS_W - 4;
   localparam int YTOP_W  = POS_W + 1;
   localparam int COL_W   = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
   localparam int ROW_W   = 3;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_DRAW = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PANELS_ACROSS = 2'd0,
      CSR_PANELS_DOWN   = 2'd1,
      CSR_FIRST_CODE    = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic             done;
      logic [REM_W-1:0] rem;
   } mod_rsp_type;

endpackage

[src/rpgr_req_if.sv]
// ----------------------------------------------------------------------------
// rpgr_req_if
// Input channel: font loads and character draws.
// ----------------------------------------------------------------------------
interface rpgr_req_if;
   logic                                valid;
   logic                                ready;
   logic [rpgr_pkg::KIND_W-1:0]         kind;
   logic [rpgr_pkg::FIDX_W-1:0]         font_index;
   logic [rpgr_pkg::FBYTE_W-1:0]        font_byte;
   logic [rpgr_pkg::CODE_W-1:0]         char_code;
   logic signed [rpgr_pkg::POS_W-1:0]   x_pos;
   logic signed [rpgr_pkg::POS_W-1:0]   y_pos;
   logic                                red_in;
   logic                                green_in;
   logic                                blue_in;

   modport source (
      output valid, kind, font_index, font_byte, char_code, x_pos, y_pos,
             red_in, green_in, blue_in,
      input  ready
   );
   modport sink (
      input  valid, kind, font_index, font_byte, char_code, x_pos, y_pos,
             red_in, green_in, blue_in,
      output ready
   );
endinterface

[src/rpgr_rsp_if.sv]
// ----------------------------------------------------------------------------
// rpgr_rsp_if
// Result channel: one physical pixel per beat.
// ----------------------------------------------------------------------------
interface rpgr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rpgr_pkg::PHYS_X_W-1:0]   phys_x;
   logic [rpgr_pkg::PHYS_Y_W-1:0]   phys_y;
   logic                            red_out;
   logic                            green_out;
   logic                            blue_out;
   logic                            last;

   modport source (
      output valid, phys_x, phys_y, red_out, green_out, blue_out, last,
      input  ready
   );
   modport sink (
      input  valid, phys_x, phys_y, red_out, green_out, blue_out, last,
      output ready
   );
endinterface

[src/rpgr_csr_if.sv]
// ----------------------------------------------------------------------------
// rpgr_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface rpgr_csr_if;
   logic                              valid;
   logic                              ready;
   logic [rpgr_pkg::CSR_IDX_W-1:0]    idx;
   logic [rpgr_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, idx, data, input ready);
   modport sink   (input valid, idx, data, output ready);
endinterface

[src/rpgr_ram.sv]
// ----------------------------------------------------------------------------
// rpgr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rpgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/rpgr_mod.sv]
// ----------------------------------------------------------------------------
// rpgr_mod
// Bit-serial floored remainder of a signed value by the panel count,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpgr_mod (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [rpgr_pkg::HI_W-1:0]    value,
   input  logic [rpgr_pkg::PAN_W-1:0]          divisor,
   output rpgr_pkg::mod_rsp_type               rsp
);
   import rpgr_pkg::*;

   localparam int CNT_W = $clog2(HI_W);

   logic                busy_ff, busy_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [HI_W-1:0]     mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [PAN_W-1:0]    rem_ff, rem_in;
   logic                done_ff, done_in;
   logic [REM_W-1:0]    res_ff, res_in;

   logic [PAN_W:0]      trial;
   logic [PAN_W-1:0]    step_rem;
   logic [PAN_W-1:0]    fix_rem;

   always_comb begin
      trial    = {rem_ff, mag_ff[HI_W-1]};
      step_rem = (trial >= {1'b0, divisor}) ? PAN_W'(trial - {1'b0, divisor})
                                             : PAN_W'(trial);
      fix_rem  = (neg_ff && (step_rem != '0)) ? PAN_W'(divisor - step_rem)
                                              : step_rem;

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      res_in  = res_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = value[HI_W-1];
         mag_in  = value[HI_W-1] ? HI_W'(-value) : HI_W'(value);
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = step_rem;
         mag_in = {mag_ff[HI_W-2:0], 1'b0};
         cnt_in = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(HI_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = REM_W'(fix_rem);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = res_ff;

endmodule

[src/rotated_panel_glyph_renderer_top.sv]
// ----------------------------------------------------------------------------
// rotated_panel_glyph_renderer_top
// Character generator for a chain of rotated 32x16 LED panels: loads a
// glyph font store and turns each drawn character into physical pixels.
//
//   channel  | dir | beat
//   ---------+-----+-----------------------------------------------
//   req_ch   | in  | font byte load or character draw
//   rsp_ch   | out | one physical pixel, last on the final one
//   csr_ch   | in  | register write (panels across/down, first code)
//
// A load, or a draw of a code outside the font, is taken without leaving
// idle. A draw works out the x wrap remainder, reads the font store, walks
// the glyph cells (35) and then flushes the held pixel; the input is held
// off until the draw is back at idle. A pixel is held back one slot so last
// can be set; a stalled result holds the walk. Reset clears control and
// registers, not the font store.
// ----------------------------------------------------------------------------
module rotated_panel_glyph_renderer_top (
   input  logic        clock,
   input  logic        reset,
   rpgr_req_if.sink    req_ch,
   rpgr_rsp_if.source  rsp_ch,
   rpgr_csr_if.sink    csr_ch
);
   import rpgr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_WALK,
      ST_FLUSH
   } state_type;

   state_type              state_ff, state_in;

   logic [PANREG_W-1:0]    across_ff, across_in;
   logic [PANREG_W-1:0]    down_ff, down_in;
   logic [FIRST_W-1:0]     first_ff, first_in;

   logic [ADDR_W-1:0]      base_ff, base_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [LX_W-1:0]        lx_ff, lx_in;
   logic [3:0]             xlo_ff, xlo_in;
   logic signed [YTOP_W-1:0] ytop_ff, ytop_in;
   logic [2:0]             rgb_ff, rgb_in;

   logic                   pend_vld_ff, pend_vld_in;
   logic [PHYS_X_W-1:0]    pend_px_ff, pend_px_in;
   logic [PHYS_Y_W-1:0]    pend_py_ff, pend_py_in;

   logic                   out_vld_ff, out_vld_in;
   logic [PHYS_X_W-1:0]    out_px_ff, out_px_in;
   logic [PHYS_Y_W-1:0]    out_py_ff, out_py_in;
   logic [2:0]             out_rgb_ff, out_rgb_in;
   logic                   out_last_ff, out_last_in;

   logic [PAN_W-1:0]       across_c, down_c;
   logic [PAN_W-1:0]       max_col;
   logic [LW_W-1:0]        log_w;
   logic [LH_W-1:0]        log_h;

   logic                   req_acc;
   logic [CODE_W-1:0]      glyph;
   logic                   code_ok;

   logic                   wr_en, rd_en;
   logic [ADDR_W-1:0]      wr_addr, rd_addr;
   logic [FBYTE_W-1:0]     rd_data;

   logic                   mod_start;
   mod_rsp_type            mod_rsp;

   logic signed [YTOP_W-1:0] ly;
   logic                   hit;
   logic                   out_free;
   logic                   stall;
   logic [LW_W-1:0]        lx_inc;
   logic [PHYS_X_W-1:0]    px;
   logic [PHYS_Y_W-1:0]    py;

   // panel counts, zero as one, saturated at the maximum
   always_comb begin
      if (across_ff == '0) begin
         across_c = PAN_W'(1);
      end else if (across_ff > PANREG_W'(MAX_PANELS)) begin
         across_c = PAN_W'(MAX_PANELS);
      end else begin
         across_c = PAN_W'(across_ff);
      end
      if (down_ff == '0) begin
         down_c = PAN_W'(1);
      end else if (down_ff > PANREG_W'(MAX_PANELS)) begin
         down_c = PAN_W'(MAX_PANELS);
      end else begin
         down_c = PAN_W'(down_ff);
      end
      max_col = PAN_W'(across_c - 1'b1);
      log_w   = LW_W'({across_c, 4'b0000});
      log_h   = LH_W'({down_c, 5'b00000});
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign glyph   = CODE_W'(req_ch.char_code - CODE_W'(first_ff));
   assign code_ok = !req_ch.char_code[CODE_W-1]
                    && (req_ch.char_code >= CODE_W'(first_ff))
                    && ({1'b0, glyph} < (CODE_W+1)'(GLYPH_COUNT));

   assign wr_en   = req_acc && (req_ch.kind == KIND_LOAD)
                    && ({1'b0, req_ch.font_index} < (FIDX_W+1)'(STORE_DEPTH));
   assign wr_addr = ADDR_W'(req_ch.font_index);

   assign mod_start = req_acc && (req_ch.kind == KIND_DRAW) && code_ok;

   // cell decode
   always_comb begin
      ly       = YTOP_W'(ytop_ff - $signed({1'b0, row_ff}));
      hit      = rd_data[row_ff] && !ly[YTOP_W-1]
                 && (ly[YTOP_W-2:0] < (YTOP_W-1)'(log_h));
      out_free = !out_vld_ff || rsp_ch.ready;
      stall    = hit && pend_vld_ff && !out_free;
      lx_inc   = LW_W'(lx_ff) + 1'b1;
      px       = PHYS_X_W'({PAN_W'(max_col - PAN_W'(lx_ff[LX_W-1:4])),
                             ~ly[4:0]});
      py       = PHYS_Y_W'({ly[LY_W-1:5], ~lx_ff[3:0]});
   end

   always_comb begin
      state_in    = state_ff;
      across_in   = across_ff;
      down_in     = down_ff;
      first_in    = first_ff;
      base_in     = base_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      lx_in       = lx_ff;
      xlo_in      = xlo_ff;
      ytop_in     = ytop_ff;
      rgb_in      = rgb_ff;
      pend_vld_in = pend_vld_ff;
      pend_px_in  = pend_px_ff;
      pend_py_in  = pend_py_ff;
      out_vld_in  = out_vld_ff && !rsp_ch.ready;
      out_px_in   = out_px_ff;
      out_py_in   = out_py_ff;
      out_rgb_in  = out_rgb_ff;
      out_last_in = out_last_ff;
      rd_en       = 1'b0;
      rd_addr     = base_ff;

      if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.idx)
            CSR_PANELS_ACROSS: across_in = PANREG_W'(csr_ch.data);
            CSR_PANELS_DOWN:   down_in   = PANREG_W'(csr_ch.data);
            CSR_FIRST_CODE:    first_in  = FIRST_W'(csr_ch.data);
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (mod_start) begin
               base_in  = ADDR_W'(ADDR_W'(glyph) * ADDR_W'(GLYPH_WIDTH));
               xlo_in   = req_ch.x_pos[3:0];
               ytop_in  = YTOP_W'(req_ch.y_pos) + YTOP_W'(GLYPH_HEIGHT - 1);
               rgb_in   = {req_ch.red_in, req_ch.green_in, req_ch.blue_in};
               col_in   = '0;
               row_in   = '0;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_rsp.done) begin
               lx_in    = {mod_rsp.rem, xlo_ff};
               rd_en    = 1'b1;
               rd_addr  = base_ff;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (!stall) begin
               if (hit) begin
                  if (pend_vld_ff) begin
                     out_vld_in  = 1'b1;
                     out_px_in   = pend_px_ff;
                     out_py_in   = pend_py_ff;
                     out_rgb_in  = rgb_ff;
                     out_last_in = 1'b0;
                  end
                  pend_vld_in = 1'b1;
                  pend_px_in  = px;
                  pend_py_in  = py;
               end
               if (row_ff == ROW_W'(GLYPH_HEIGHT - 1)) begin
                  row_in = '0;
                  if (col_ff == COL_W'(GLYPH_WIDTH - 1)) begin
                     state_in = ST_FLUSH;
                  end else begin
                     col_in  = COL_W'(col_ff + 1'b1);
                     lx_in   = (lx_inc == log_w) ? '0 : LX_W'(lx_inc);
                     rd_en   = 1'b1;
                     rd_addr = ADDR_W'(base_ff + ADDR_W'(col_ff) + 1'b1);
                  end
               end else begin
                  row_in = ROW_W'(row_ff + 1'b1);
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_vld_in  = 1'b1;
               out_px_in   = pend_px_ff;
               out_py_in   = pend_py_ff;
               out_rgb_in  = rgb_ff;
               out_last_in = 1'b1;
               pend_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         across_ff   <= PANREG_W'(1);
         down_ff     <= PANREG_W'(1);
         first_ff    <= FIRST_W'(32);
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         across_ff   <= across_in;
         down_ff     <= down_in;
         first_ff    <= first_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
      base_ff     <= base_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      lx_ff       <= lx_in;
      xlo_ff      <= xlo_in;
      ytop_ff     <= ytop_in;
      rgb_ff      <= rgb_in;
      pend_px_ff  <= pend_px_in;
      pend_py_ff  <= pend_py_in;
      out_px_ff   <= out_px_in;
      out_py_ff   <= out_py_in;
      out_rgb_ff  <= out_rgb_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_ch.valid     = out_vld_ff;
   assign rsp_ch.phys_x    = out_px_ff;
   assign rsp_ch.phys_y    = out_py_ff;
   assign rsp_ch.red_out   = out_rgb_ff[2];
   assign rsp_ch.green_out = out_rgb_ff[1];
   assign rsp_ch.blue_out  = out_rgb_ff[0];
   assign rsp_ch.last      = out_last_ff;

   rpgr_ram #(
      .WIDTH (FBYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_font_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ch.font_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rpgr_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .value   ($signed(req_ch.x_pos[POS_W-1:4])),
      .divisor (across_c),
      .rsp     (mod_rsp)
   );

   a_pend_flushed: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> (state_ff != ST_IDLE))
      else $error("held pixel left behind at idle");

   a_walk_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |->
         ((row_ff < ROW_W'(GLYPH_HEIGHT)) && (col_ff < COL_W'(GLYPH_WIDTH))))
      else $error("cell walk out of glyph");

   a_rd_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> ({1'b0, rd_addr} < (ADDR_W+1)'(STORE_DEPTH)))
      else $error("font read beyond store");

   a_mod_done: assert property (@(posedge clock) disable iff (reset)
      mod_rsp.done |-> (state_ff == ST_MOD))
      else $error("remainder result outside wait state");

   a_mod_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD) && mod_rsp.done |=> ({1'b0, lx_ff} < log_w))
      else $error("wrapped x beyond logical width");

endmodule

[tb/rpgr_glyph_checker.sv]
// ----------------------------------------------------------------------------
// rpgr_glyph_checker
// Watches the load/draw, pixel and register channels of the rotated panel
// glyph renderer. It keeps its own font store and register copies, works out
// the pixels each draw must give, and compares every pixel beat in order.
// ----------------------------------------------------------------------------
module rpgr_glyph_checker (
   input  logic clock,
   input  logic reset,
   rpgr_req_if  req_mon,
   rpgr_rsp_if  rsp_mon,
   rpgr_csr_if  csr_mon,
   output int   fail_count,
   output int   pending
);
   import rpgr_pkg::*;

   localparam int PANEL_W    = 32;
   localparam int PANEL_H    = 16;
   localparam int CODE_LIMIT = 128;

   localparam logic [PANREG_W-1:0] RESET_PANELS     = PANREG_W'(1);
   localparam logic [FIRST_W-1:0]  RESET_FIRST_CODE = FIRST_W'(32);

   typedef struct packed {
      logic [PHYS_X_W-1:0] phys_x;
      logic [PHYS_Y_W-1:0] phys_y;
      logic                red;
      logic                green;
      logic                blue;
      logic                last;
   } pixel_type;

   logic [FBYTE_W-1:0]  font_rom [STORE_DEPTH];
   logic [PANREG_W-1:0] across_reg = RESET_PANELS;
   logic [PANREG_W-1:0] down_reg   = RESET_PANELS;
   logic [FIRST_W-1:0]  first_reg  = RESET_FIRST_CODE;
   pixel_type           pixel_q [$];
   int                  mismatches = 0;

   assign fail_count = mismatches;

   function automatic int panel_count(input logic [PANREG_W-1:0] n);
      if (n == 0) return 1;
      if (n > MAX_PANELS) return MAX_PANELS;
      return int'(n);
   endfunction

   // queues the physical pixels of one character; the last one is held back
   // until the walk ends so that it can carry last
   function automatic void render_glyph(input int code, input int xo, input int yo,
                                        input logic red, input logic green,
                                        input logic blue);
      int        across, down, lw, lh, glyph, lx, ly, col, row;
      logic [FBYTE_W-1:0] bits;
      pixel_type held;
      bit        have;
      have = 1'b0;
      held = '0;
      if (code >= CODE_LIMIT || code < first_reg || code >= first_reg + GLYPH_COUNT)
         return;
      glyph  = code - first_reg;
      across = panel_count(across_reg);
      down   = panel_count(down_reg);
      lw     = across * PANEL_H;
      lh     = down * PANEL_W;
      for (col = 0; col < GLYPH_WIDTH; col++) begin
         bits = font_rom[glyph * GLYPH_WIDTH + col];
         for (row = 0; row < GLYPH_HEIGHT; row++) begin
            if (!bits[row]) continue;
            lx = (xo + col) % lw;
            if (lx < 0) lx += lw;
            ly = yo + GLYPH_HEIGHT - 1 - row;
            if (ly < 0 || ly >= lh) continue;
            if (have) pixel_q.push_back(held);
            held.phys_x = PHYS_X_W'((across - 1 - lx / PANEL_H) * PANEL_W
                                    + (PANEL_W - 1 - ly % PANEL_W));
            held.phys_y = PHYS_Y_W'((ly / PANEL_W) * PANEL_H
                                    + (PANEL_H - 1 - lx % PANEL_H));
            held.red    = red;
            held.green  = green;
            held.blue   = blue;
            held.last   = 1'b0;
            have        = 1'b1;
         end
      end
      if (have) begin
         held.last = 1'b1;
         pixel_q.push_back(held);
      end
   endfunction

   function automatic void check_field(input string name, input logic [8:0] want_v,
                                       input logic [8:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, actual %0d", name, want_v, got_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      pixel_type want;
      if (reset) begin
         across_reg = RESET_PANELS;
         down_reg   = RESET_PANELS;
         first_reg  = RESET_FIRST_CODE;
         pixel_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pixel_q.size() == 0) begin
               $error("pixel beat x %0d y %0d with nothing expected",
                      rsp_mon.phys_x, rsp_mon.phys_y);
               mismatches++;
            end else begin
               want = pixel_q.pop_front();
               check_field("phys_x", 9'(want.phys_x), 9'(rsp_mon.phys_x));
               check_field("phys_y", 9'(want.phys_y), 9'(rsp_mon.phys_y));
               check_field("red_out", 9'(want.red), 9'(rsp_mon.red_out));
               check_field("green_out", 9'(want.green), 9'(rsp_mon.green_out));
               check_field("blue_out", 9'(want.blue), 9'(rsp_mon.blue_out));
               check_field("last", 9'(want.last), 9'(rsp_mon.last));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.kind == KIND_LOAD) begin
               if (req_mon.font_index < STORE_DEPTH)
                  font_rom[req_mon.font_index] = req_mon.font_byte;
            end else begin
               render_glyph(int'(req_mon.char_code), $signed(req_mon.x_pos),
                            $signed(req_mon.y_pos), req_mon.red_in, req_mon.green_in,
                            req_mon.blue_in);
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_idx_type'(csr_mon.idx))
               CSR_PANELS_ACROSS: across_reg = csr_mon.data[PANREG_W-1:0];
               CSR_PANELS_DOWN:   down_reg   = csr_mon.data[PANREG_W-1:0];
               CSR_FIRST_CODE:    first_reg  = csr_mon.data[FIRST_W-1:0];
               default: ;
            endcase
         end
      end
      pending <= pixel_q.size();
   end

endmodule

[tb/tb_rotated_panel_glyph_renderer_top.sv]
// ----------------------------------------------------------------------------
// tb_rotated_panel_glyph_renderer_top
// Loads every glyph the draws use, then drives directed draws (edge glyphs,
// rejected codes, wrap and clipping, panel count limits) and random load/draw
// traffic over several panel settings, with random idling on both channels
// and one long pixel back-pressure stretch. Checking is done by
// rpgr_glyph_checker.
// ----------------------------------------------------------------------------
module tb_rotated_panel_glyph_renderer_top;
   import rpgr_pkg::*;

   localparam int PANEL_W        = 32;
   localparam int PANEL_H        = 16;
   localparam int CODE_LIMIT     = 128;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 150;
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_PHASES  = 5;
   localparam int PHASE_ITEMS    = 30;
   localparam int FILL_GLYPHS    = 32;
   // glyph of code 127 when the first code is 63
   localparam int LIMIT_GLYPH    = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rpgr_req_if req_ch();
   rpgr_rsp_if rsp_ch();
   rpgr_csr_if csr_ch();

   int fail_count;
   int pending;
   int load_count    = 0;
   int draw_count    = 0;
   int pixel_count   = 0;
   int setting_count = 0;
   int quiet_cycles  = 0;
   int log_w         = PANEL_H;
   int log_h         = PANEL_W;
   int first_code_now = 32;
   bit idle_on   = 1'b1;
   bit sink_hold = 1'b0;

   rotated_panel_glyph_renderer_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   rpgr_glyph_checker u_chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_mon    (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) pixel_count <= pixel_count + 1;
   end

   // no beat on any channel for too long ends the run
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // pixel sink: random ready, plus one long hold on request
   initial begin : pixel_sink
      int span;
      rsp_ch.ready = 1'b0;
      forever begin
         if (sink_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            sink_hold = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            span = $urandom_range(1, 15);
            rsp_ch.ready <= 1'b0;
            repeat (span) @(posedge clock);
         end else begin
            span = $urandom_range(1, 24);
            rsp_ch.ready <= 1'b1;
            repeat (span) @(posedge clock);
         end
      end
   end

   // glyphs whose font bytes are loaded before any draw
   function automatic bit glyph_loaded(input int g);
      return (g < FILL_GLYPHS) || (g == LIMIT_GLYPH) || (g == GLYPH_COUNT - 1);
   endfunction

   // keeps an accepted code on a loaded glyph
   function automatic int loaded_code(input int code);
      int g;
      g = code - first_code_now;
      if (code >= CODE_LIMIT || g < 0 || g >= GLYPH_COUNT || glyph_loaded(g))
         return code;
      return first_code_now + g % FILL_GLYPHS;
   endfunction

   task automatic send_beat(input logic kind, input logic [FIDX_W-1:0] fidx,
                            input logic [FBYTE_W-1:0] fbits, input logic [CODE_W-1:0] code,
                            input logic [POS_W-1:0] xv, input logic [POS_W-1:0] yv,
                            input logic [2:0] rgb);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= kind;
      req_ch.font_index <= fidx;
      req_ch.font_byte  <= fbits;
      req_ch.char_code  <= code;
      req_ch.x_pos      <= xv;
      req_ch.y_pos      <= yv;
      req_ch.red_in     <= rgb[2];
      req_ch.green_in   <= rgb[1];
      req_ch.blue_in    <= rgb[0];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_load(input int addr, input logic [FBYTE_W-1:0] col_bits);
      send_beat(KIND_LOAD, FIDX_W'(addr), col_bits, CODE_W'($urandom),
                POS_W'($urandom), POS_W'($urandom), 3'($urandom));
      load_count++;
   endtask

   task automatic send_draw(input int code, input int xv, input int yv,
                            input logic [2:0] rgb);
      send_beat(KIND_DRAW, FIDX_W'($urandom), FBYTE_W'($urandom), CODE_W'(code),
                POS_W'(xv), POS_W'(yv), rgb);
      draw_count++;
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.idx   <= idx;
      csr_ch.data  <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] across,
                             input logic [CSR_DATA_W-1:0] down,
                             input logic [CSR_DATA_W-1:0] first);
      write_reg(CSR_PANELS_ACROSS, across);
      write_reg(CSR_PANELS_DOWN, down);
      write_reg(CSR_FIRST_CODE, first);
      csr_ch.valid <= 1'b0;
      setting_count++;
   endtask

   // all pixels in, then time for any trailing empty draws to finish
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_item();
      int pick, code, xv, yv;
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         send_load(int'($urandom_range(0, (pick == 0) ? 511 : STORE_DEPTH - 1)),
                   FBYTE_W'($urandom_range(0, 255)));
      end else begin
         if (pick == 2) code = loaded_code(int'($urandom_range(0, 255)));
         else code = first_code_now + int'($urandom_range(0, FILL_GLYPHS - 1));
         if (pick == 3) begin
            xv = int'($urandom_range(0, 4095)) - 2048;
            yv = int'($urandom_range(0, 4095)) - 2048;
         end else begin
            xv = int'($urandom_range(0, log_w + 11)) - 6;
            yv = int'($urandom_range(0, log_h + 13)) - 8;
         end
         send_draw(code, xv, yv, 3'($urandom_range(0, 7)));
      end
   endtask

   initial begin : stimulus
      int g, c, ph, n, pa, pd, fc;
      logic [FBYTE_W-1:0] col_bits;
      req_ch.valid      = 1'b0;
      req_ch.kind       = KIND_LOAD;
      req_ch.font_index = '0;
      req_ch.font_byte  = '0;
      req_ch.char_code  = '0;
      req_ch.x_pos      = '0;
      req_ch.y_pos      = '0;
      req_ch.red_in     = 1'b0;
      req_ch.green_in   = 1'b0;
      req_ch.blue_in    = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.idx        = CSR_PANELS_ACROSS;
      csr_ch.data       = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // font first: glyph 0 blank, glyph 1 solid, rest random
      for (g = 0; g < GLYPH_COUNT; g++) begin
         if (glyph_loaded(g)) begin
            for (c = 0; c < GLYPH_WIDTH; c++) begin
               if (g == 0) col_bits = 8'h00;
               else if (g == 1) col_bits = 8'hFF;
               else col_bits = FBYTE_W'($urandom_range(0, 255));
               send_load(g * GLYPH_WIDTH + c, col_bits);
            end
         end
      end

      // reset settings: one panel, first code 32
      send_draw(33, 0, 0, 3'b111);
      send_draw(32, 5, 5, 3'b101);
      send_draw(31, 0, 0, 3'b111);
      send_draw(128, 0, 0, 3'b111);
      send_draw(255, 0, 0, 3'b111);
      send_draw(127, 3, 10, 3'b010);
      send_draw(33, -3, 28, 3'b100);
      send_draw(33, 14, -3, 3'b001);
      send_draw(33, -2048, -2048, 3'b011);
      send_draw(33, 2047, 2047, 3'b110);
      send_draw(33, 2047, 0, 3'b101);
      send_draw(33, -2048, 25, 3'b111);
      send_load(480, 8'hAA);
      send_load(511, 8'h55);
      send_draw(33, 0, 10, 3'b000);
      wait_idle();

      // zero panel counts act as one
      set_config(CSR_DATA_W'(0), CSR_DATA_W'(0), CSR_DATA_W'(0));
      send_draw(0, 0, 0, 3'b111);
      send_draw(1, 0, 0, 3'b110);
      send_draw(95, 8, 20, 3'b011);
      send_draw(96, 0, 0, 3'b111);
      wait_idle();

      set_config(CSR_DATA_W'(MAX_PANELS), CSR_DATA_W'(MAX_PANELS), CSR_DATA_W'(32));
      send_draw(33, 250, 505, 3'b111);
      send_draw(33, 255, 0, 3'b001);
      send_draw(60, -1, 300, 3'b100);
      wait_idle();

      // oversize panel counts saturate; codes run into the 128 limit
      set_config(6'h3F, CSR_DATA_W'(17), CSR_DATA_W'(63));
      send_draw(63, 0, 0, 3'b111);
      send_draw(64, 100, 200, 3'b010);
      send_draw(62, 0, 0, 3'b111);
      send_draw(127, 40, 40, 3'b101);
      send_draw(128, 0, 0, 3'b111);

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         pa = $urandom_range(1, MAX_PANELS);
         pd = $urandom_range(1, MAX_PANELS);
         fc = $urandom_range(0, 63);
         set_config(CSR_DATA_W'(pa), CSR_DATA_W'(pd), CSR_DATA_W'(fc));
         log_w          = pa * PANEL_H;
         log_h          = pd * PANEL_W;
         first_code_now = fc;
         if (ph == RANDOM_PHASES - 1) idle_on = 1'b0;
         if (ph == 1) sink_hold = 1'b1;
         for (n = 0; n < PHASE_ITEMS; n++) random_item();
      end
      wait_idle();

      $display("Covered %0d font loads and %0d draws over %0d register settings",
               load_count, draw_count, setting_count);
      $display("%0d pixel beats compared, %0d mismatches", pixel_count, fail_count);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
